/* sv/mi4_pkg.sv */
// shared types, defaults and cofactor index functions for the 4x4 matrix inverse
// depends on nothing; imported by mi4_alu and matrix_inverse_4x4
package mi4_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD_B,
        ST_RD_C,
        ST_LD_C,
        ST_MUL_BC,
        ST_RD_A,
        ST_LD_A,
        ST_MUL_A,
        ST_COF_WR,
        ST_DET_RD,
        ST_DET_LD,
        ST_DET_MUL,
        ST_DET_ABS,
        ST_DIV_RD,
        ST_DIV_LD,
        ST_DIV_RUN,
        ST_DIV_OUT
    } state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t op;
    } alu_ctrl_t;

    // column order of the six terms of a 3x3 determinant
    function automatic logic [1:0] perm_col(input logic [2:0] t, input logic [1:0] j);
        logic [5:0] p;
        case (t)
            3'd0:    p = {2'd2, 2'd1, 2'd0};
            3'd1:    p = {2'd1, 2'd2, 2'd0};
            3'd2:    p = {2'd2, 2'd0, 2'd1};
            3'd3:    p = {2'd0, 2'd2, 2'd1};
            3'd4:    p = {2'd1, 2'd0, 2'd2};
            3'd5:    p = {2'd0, 2'd1, 2'd2};
            default: p = {2'd2, 2'd1, 2'd0};
        endcase
        return p[2*j +: 2];
    endfunction

    // store address of operand j of term t of cofactor k (minor drops row c, column r)
    function automatic logic [3:0] cof_index(input logic [3:0] k, input logic [2:0] t,
                                             input logic [1:0] j);
        logic [1:0] sr;
        logic [1:0] sc;
        logic [1:0] pc;
        logic [1:0] row;
        logic [1:0] col;
        sr  = k[1:0];
        sc  = k[3:2];
        pc  = perm_col(t, j);
        row = (j < sr) ? j : j + 2'd1;
        col = (pc < sc) ? pc : pc + 2'd1;
        return {row, col};
    endfunction

    // term parity combined with the checkerboard sign of the cofactor
    function automatic logic term_neg(input logic [3:0] k, input logic [2:0] t);
        logic odd;
        odd = (t == 3'd1) || (t == 3'd2) || (t == 3'd5);
        return odd ^ k[0] ^ k[2];
    endfunction

endpackage

/* sv/mi4_ram.sv */
// generic single write port, single read port ram with registered read
// depends on nothing
module mi4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/mi4_alu.sv */
// shared wide add/subtract unit used for shift-add multiply and restoring divide
// depends on mi4_pkg
module mi4_alu #(
    parameter int WIDTH = 134
) (
    input  logic [WIDTH-1:0]  a,
    input  logic [WIDTH-1:0]  b,
    input  mi4_pkg::alu_ctrl_t ctrl,
    output logic [WIDTH-1:0]  result,
    output logic              borrow
);

    import mi4_pkg::*;

    logic [WIDTH:0] full;

    always_comb
    begin
        case (ctrl.op)
            ALU_ADD: full = {1'b0, a} + {1'b0, b};
            ALU_SUB: full = {1'b0, a} - {1'b0, b};
            default: full = {1'b0, a} + {1'b0, b};
        endcase
    end

    assign result = full[WIDTH-1:0];
    assign borrow = full[WIDTH] & (ctrl.op == ALU_SUB);

endmodule

/* sv/matrix_inverse_4x4.sv */
// top level of the 4x4 fixed-point matrix inverse: sequencer, datapath registers
// depends on mi4_pkg, mi4_ram, mi4_alu
//
// Elements are written one per start pulse in row-major order; busy stays low while
// loading. The sixteenth element starts the inversion and busy goes high until the last
// result. Everything runs through one shared add/subtract unit: each of the 96 triple
// products takes two shift-add multiplies plus memory access, each of the 16 cofactors
// is then stored, the determinant takes four more multiplies, and each of the 16
// divisions is a restoring divide. The 16 results leave on strobe, one cycle each with
// gaps between them, and the receiver cannot stall them.
module matrix_inverse_4x4 #(
    parameter int DATA_WIDTH = mi4_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = mi4_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [DATA_WIDTH-1:0] element_value,
    output logic                         strobe,
    output logic signed [DATA_WIDTH-1:0] inverse_value,
    output logic [3:0]                   element_index,
    output logic                         last_element,
    output logic                         singular,
    output logic                         saturated
);

    import mi4_pkg::*;

    localparam int W    = DATA_WIDTH;
    localparam int CW   = 3 * W + 3;
    localparam int AW   = 4 * W + 6;
    localparam int NW   = 3 * W + 2 * FRAC_BITS + 3;
    localparam int CNTW = $clog2(NW + 1);

    state_t           state_reg, state_next;
    logic [3:0]       load_count_reg, load_count_next;
    logic [3:0]       k_reg, k_next;
    logic [2:0]       t_reg, t_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;
    logic [W-1:0]     x_reg, x_next;
    logic [AW-1:0]    y_reg, y_next;
    logic [2*W-1:0]   tmp_reg, tmp_next;
    logic [CW-1:0]    cof_acc_reg, cof_acc_next;
    logic [AW-1:0]    det_reg, det_next;
    logic [AW-1:0]    dmag_reg, dmag_next;
    logic             sing_reg, sing_next;
    logic [AW-1:0]    rem_reg, rem_next;
    logic [NW-1:0]    num_reg, num_next;
    logic [W+1:0]     q_reg, q_next;
    logic             ovf_reg, ovf_next;
    logic             neg_reg, neg_next;

    logic             strobe_reg, strobe_next;
    logic [W-1:0]     value_reg, value_next;
    logic [3:0]       index_reg, index_next;
    logic             last_reg, last_next;
    logic             singular_reg, singular_next;
    logic             saturated_reg, saturated_next;

    logic             mat_we;
    logic [3:0]       mat_raddr;
    logic [W-1:0]     mat_rdata;
    logic             cof_we;
    logic [3:0]       cof_raddr;
    logic [CW-1:0]    cof_rdata;

    logic [AW-1:0]    alu_a;
    logic [AW-1:0]    alu_b;
    alu_ctrl_t        alu_ctrl;
    logic [AW-1:0]    alu_res;
    logic             alu_borrow;

    logic             accept;
    logic             mul_last;
    logic [W+2:0]     q_inc;
    logic [W+1:0]     q_round;
    logic             over_pos;
    logic             over_neg;

    assign accept   = start && (state_reg == ST_IDLE);
    assign mul_last = (cnt_reg == CNTW'(W - 1));
    assign mat_we   = accept;
    assign cof_we   = (state_reg == ST_COF_WR);

    mi4_ram #(
        .WIDTH (W),
        .DEPTH (16)
    ) u_mat_ram (
        .clk   (clk),
        .we    (mat_we),
        .waddr (load_count_reg),
        .wdata (element_value),
        .raddr (mat_raddr),
        .rdata (mat_rdata)
    );

    mi4_ram #(
        .WIDTH (CW),
        .DEPTH (16)
    ) u_cof_ram (
        .clk   (clk),
        .we    (cof_we),
        .waddr (k_reg),
        .wdata (cof_acc_reg),
        .raddr (cof_raddr),
        .rdata (cof_rdata)
    );

    mi4_alu #(
        .WIDTH (AW)
    ) u_alu (
        .a      (alu_a),
        .b      (alu_b),
        .ctrl   (alu_ctrl),
        .result (alu_res),
        .borrow (alu_borrow)
    );

    // rounding: q holds floor(2x), result is floor((q+1)/2)
    assign q_inc    = {1'b0, q_reg} + (W + 3)'(1);
    assign q_round  = q_inc[W+2:1];
    assign over_pos = ovf_reg || (q_round[W+1:W-1] != 3'b000);
    assign over_neg = ovf_reg || (q_round[W+1:W] != 2'b00)
                      || (q_round[W-1] && (q_round[W-2:0] != '0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            load_count_reg <= '0;
            k_reg          <= '0;
            t_reg          <= '0;
            cnt_reg        <= '0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            k_reg          <= k_next;
            t_reg          <= t_next;
            cnt_reg        <= cnt_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        y_reg         <= y_next;
        tmp_reg       <= tmp_next;
        cof_acc_reg   <= cof_acc_next;
        det_reg       <= det_next;
        dmag_reg      <= dmag_next;
        sing_reg      <= sing_next;
        rem_reg       <= rem_next;
        num_reg       <= num_next;
        q_reg         <= q_next;
        ovf_reg       <= ovf_next;
        neg_reg       <= neg_next;
        value_reg     <= value_next;
        index_reg     <= index_next;
        last_reg      <= last_next;
        singular_reg  <= singular_next;
        saturated_reg <= saturated_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        k_next          = k_reg;
        t_next          = t_reg;
        cnt_next        = cnt_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        tmp_next        = tmp_reg;
        cof_acc_next    = cof_acc_reg;
        det_next        = det_reg;
        dmag_next       = dmag_reg;
        sing_next       = sing_reg;
        rem_next        = rem_reg;
        num_next        = num_reg;
        q_next          = q_reg;
        ovf_next        = ovf_reg;
        neg_next        = neg_reg;
        strobe_next     = 1'b0;
        value_next      = value_reg;
        index_next      = index_reg;
        last_next       = last_reg;
        singular_next   = singular_reg;
        saturated_next  = saturated_reg;
        mat_raddr       = '0;
        cof_raddr       = '0;
        alu_a           = '0;
        alu_b           = '0;
        alu_ctrl.op     = ALU_ADD;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    load_count_next = load_count_reg + 4'd1;
                    if (load_count_reg == 4'd15)
                    begin
                        k_next       = '0;
                        t_next       = '0;
                        cof_acc_next = '0;
                        state_next   = ST_RD_B;
                    end
                end
            end

            ST_RD_B:
            begin
                mat_raddr  = cof_index(k_reg, t_reg, 2'd1);
                state_next = ST_RD_C;
            end

            ST_RD_C:
            begin
                mat_raddr  = cof_index(k_reg, t_reg, 2'd2);
                x_next     = mat_rdata;
                state_next = ST_LD_C;
            end

            ST_LD_C:
            begin
                y_next     = {{(AW-W){mat_rdata[W-1]}}, mat_rdata};
                tmp_next   = '0;
                cnt_next   = '0;
                state_next = ST_MUL_BC;
            end

            ST_MUL_BC:
            begin
                alu_a       = {{(AW-2*W){tmp_reg[2*W-1]}}, tmp_reg};
                alu_b       = x_reg[0] ? y_reg : '0;
                alu_ctrl.op = mul_last ? ALU_SUB : ALU_ADD;
                tmp_next    = alu_res[2*W-1:0];
                x_next      = x_reg >> 1;
                y_next      = y_reg << 1;
                cnt_next    = cnt_reg + CNTW'(1);
                if (mul_last)
                begin
                    state_next = ST_RD_A;
                end
            end

            ST_RD_A:
            begin
                mat_raddr  = cof_index(k_reg, t_reg, 2'd0);
                state_next = ST_LD_A;
            end

            ST_LD_A:
            begin
                x_next     = mat_rdata;
                y_next     = {{(AW-2*W){tmp_reg[2*W-1]}}, tmp_reg};
                cnt_next   = '0;
                state_next = ST_MUL_A;
            end

            ST_MUL_A:
            begin
                alu_a        = {{(AW-CW){cof_acc_reg[CW-1]}}, cof_acc_reg};
                alu_b        = x_reg[0] ? y_reg : '0;
                alu_ctrl.op  = (mul_last ^ term_neg(k_reg, t_reg)) ? ALU_SUB : ALU_ADD;
                cof_acc_next = alu_res[CW-1:0];
                x_next       = x_reg >> 1;
                y_next       = y_reg << 1;
                cnt_next     = cnt_reg + CNTW'(1);
                if (mul_last)
                begin
                    if (t_reg == 3'd5)
                    begin
                        state_next = ST_COF_WR;
                    end
                    else
                    begin
                        t_next     = t_reg + 3'd1;
                        state_next = ST_RD_B;
                    end
                end
            end

            ST_COF_WR:
            begin
                cof_acc_next = '0;
                t_next       = '0;
                if (k_reg == 4'd15)
                begin
                    k_next     = '0;
                    det_next   = '0;
                    state_next = ST_DET_RD;
                end
                else
                begin
                    k_next     = k_reg + 4'd1;
                    state_next = ST_RD_B;
                end
            end

            ST_DET_RD:
            begin
                mat_raddr  = {2'b00, k_reg[1:0]};
                cof_raddr  = {k_reg[1:0], 2'b00};
                state_next = ST_DET_LD;
            end

            ST_DET_LD:
            begin
                x_next     = mat_rdata;
                y_next     = {{(AW-CW){cof_rdata[CW-1]}}, cof_rdata};
                cnt_next   = '0;
                state_next = ST_DET_MUL;
            end

            ST_DET_MUL:
            begin
                alu_a       = det_reg;
                alu_b       = x_reg[0] ? y_reg : '0;
                alu_ctrl.op = mul_last ? ALU_SUB : ALU_ADD;
                det_next    = alu_res;
                x_next      = x_reg >> 1;
                y_next      = y_reg << 1;
                cnt_next    = cnt_reg + CNTW'(1);
                if (mul_last)
                begin
                    if (k_reg[1:0] == 2'd3)
                    begin
                        k_next     = '0;
                        state_next = ST_DET_ABS;
                    end
                    else
                    begin
                        k_next     = k_reg + 4'd1;
                        state_next = ST_DET_RD;
                    end
                end
            end

            ST_DET_ABS:
            begin
                alu_a       = '0;
                alu_b       = det_reg;
                alu_ctrl.op = ALU_SUB;
                dmag_next   = det_reg[AW-1] ? alu_res : det_reg;
                sing_next   = (det_reg == '0);
                state_next  = ST_DIV_RD;
            end

            ST_DIV_RD:
            begin
                cof_raddr  = k_reg;
                state_next = ST_DIV_LD;
            end

            ST_DIV_LD:
            begin
                alu_a       = '0;
                alu_b       = {{(AW-CW){cof_rdata[CW-1]}}, cof_rdata};
                alu_ctrl.op = ALU_SUB;
                num_next    = {(cof_rdata[CW-1] ? alu_res[CW-2:0] : cof_rdata[CW-2:0]),
                               {(2*FRAC_BITS+1){1'b0}}};
                neg_next    = cof_rdata[CW-1] ^ det_reg[AW-1];
                rem_next    = '0;
                q_next      = '0;
                ovf_next    = 1'b0;
                cnt_next    = '0;
                state_next  = sing_reg ? ST_DIV_OUT : ST_DIV_RUN;
            end

            ST_DIV_RUN:
            begin
                alu_a       = {rem_reg[AW-2:0], num_reg[NW-1]};
                alu_b       = dmag_reg;
                alu_ctrl.op = ALU_SUB;
                rem_next    = alu_borrow ? alu_a : alu_res;
                q_next      = {q_reg[W:0], ~alu_borrow};
                ovf_next    = ovf_reg | q_reg[W+1];
                num_next    = num_reg << 1;
                cnt_next    = cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(NW - 1))
                begin
                    state_next = ST_DIV_OUT;
                end
            end

            ST_DIV_OUT:
            begin
                strobe_next   = 1'b1;
                index_next    = k_reg;
                last_next     = (k_reg == 4'd15);
                singular_next = sing_reg;
                if (sing_reg)
                begin
                    value_next     = '0;
                    saturated_next = 1'b0;
                end
                else if (!neg_reg)
                begin
                    value_next     = over_pos ? {1'b0, {(W-1){1'b1}}} : q_round[W-1:0];
                    saturated_next = over_pos;
                end
                else
                begin
                    value_next     = over_neg ? {1'b1, {(W-1){1'b0}}} : (~q_round[W-1:0] + 1'b1);
                    saturated_next = over_neg;
                end
                if (k_reg == 4'd15)
                begin
                    k_next     = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    k_next     = k_reg + 4'd1;
                    state_next = ST_DIV_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy          = (state_reg != ST_IDLE);
    assign strobe        = strobe_reg;
    assign inverse_value = value_reg;
    assign element_index = index_reg;
    assign last_element  = last_reg & strobe_reg;
    assign singular      = singular_reg;
    assign saturated     = saturated_reg;

    a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && load_count_reg != 4'd15) |=> !busy)
        else $error("busy after a non-final element");

    a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> (load_count_reg == 4'd0 && $past(load_count_reg) == 4'd15))
        else $error("inversion started without a full matrix");

    a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last_element) |-> (!busy && element_index == 4'd15))
        else $error("last result out of place");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && singular) |-> (inverse_value == '0 && !saturated))
        else $error("singular result not zero");

    a_no_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last_element) |-> busy)
        else $error("result outside an inversion");

endmodule
